FILE: hdl/sdip_pkg.sv
`timescale 1ns / 1ps
// Package for the strict decimal integer parser: widths, phase codes, state struct.
// No dependencies.
package sdip_pkg;

    localparam int VALUE_BITS = 32;   // internal magnitude width, 8..64
    localparam int OUT_BITS   = 32;   // width of the result value port
    localparam int BYTE_BITS  = 8;

    localparam logic [BYTE_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_TRAIL = 3'd3,
        PH_DONE  = 3'd4,
        PH_FAIL  = 3'd5
    } parse_phase_t;

    typedef struct packed {
        parse_phase_t          phase;
        logic                  is_neg;
        logic [VALUE_BITS-1:0] mag;
        logic                  oor;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:  PH_LEAD,
        is_neg: 1'b0,
        mag:    '0,
        oor:    1'b0
    };

    function automatic logic is_ws(input logic [BYTE_BITS-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [BYTE_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

FILE: hdl/sdip_step.sv
`timescale 1ns / 1ps
// One parse step: next parser state and result value for a single byte beat.
// Depends on sdip_pkg.
module sdip_step (
    input  sdip_pkg::parse_state_t          st,
    input  logic [sdip_pkg::BYTE_BITS-1:0]  char_byte,
    input  logic                            no_byte,
    input  logic                            last_byte,
    output sdip_pkg::parse_state_t          st_next,
    output logic [sdip_pkg::OUT_BITS-1:0]   res_value,
    output logic                            res_ok
);
    import sdip_pkg::*;

    localparam int SUM_BITS = VALUE_BITS + 4;

    logic                  c_ws;
    logic                  c_digit;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] lim;
    logic [SUM_BITS-1:0]   mag_ext;
    logic [SUM_BITS-1:0]   sum;
    logic                  over;
    logic [VALUE_BITS-1:0] mag_add;
    logic                  take_digit;
    logic                  set_sign;
    parse_phase_t          phase_after;
    parse_state_t          st_after;
    logic signed [VALUE_BITS-1:0] sval;

    assign c_ws    = is_ws(char_byte);
    assign c_digit = is_digit(char_byte);
    assign digit   = char_byte[3:0];

    // limit is 2^(N-1) for negative, 2^(N-1)-1 otherwise
    assign lim     = {1'b1, {(VALUE_BITS-1){1'b0}}} - {{(VALUE_BITS-1){1'b0}}, ~st.is_neg};
    assign mag_ext = {4'b0, st.mag};
    // mag*10 + d, compared against the limit instead of dividing it down
    assign sum     = (mag_ext << 3) + (mag_ext << 1) + {{(SUM_BITS-4){1'b0}}, digit};
    assign over    = st.oor || (sum > {4'b0, lim});
    assign mag_add = over ? lim : sum[VALUE_BITS-1:0];

    // next phase
    always_comb begin
        phase_after = st.phase;
        take_digit  = 1'b0;
        set_sign    = 1'b0;
        if (!no_byte) begin
            unique case (st.phase)
                PH_LEAD: begin
                    priority if (c_ws) begin
                        phase_after = PH_LEAD;
                    end else if (char_byte == CH_NUL) begin
                        phase_after = PH_DONE;
                    end else if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
                        set_sign    = 1'b1;
                        phase_after = PH_SIGN;
                    end else if (c_digit) begin
                        take_digit  = 1'b1;
                        phase_after = PH_DIGIT;
                    end else begin
                        phase_after = PH_FAIL;
                    end
                end
                PH_SIGN: begin
                    if (c_digit) begin
                        take_digit  = 1'b1;
                        phase_after = PH_DIGIT;
                    end else begin
                        phase_after = PH_FAIL;
                    end
                end
                PH_DIGIT: begin
                    priority if (c_digit) begin
                        take_digit = 1'b1;
                    end else if (char_byte == CH_NUL) begin
                        phase_after = PH_DONE;
                    end else if (c_ws) begin
                        phase_after = PH_TRAIL;
                    end else begin
                        phase_after = PH_FAIL;
                    end
                end
                PH_TRAIL: begin
                    if (!c_ws) begin
                        phase_after = PH_FAIL;
                    end
                end
                PH_DONE: begin
                    phase_after = PH_DONE;
                end
                default: begin
                    phase_after = PH_FAIL;
                end
            endcase
        end
    end

    // datapath and result
    always_comb begin
        st_after        = st;
        st_after.phase  = phase_after;
        if (set_sign) begin
            st_after.is_neg = (char_byte == CH_MINUS);
        end
        if (take_digit) begin
            st_after.mag = mag_add;
            st_after.oor = over;
        end

        res_ok = ((st_after.phase == PH_DIGIT) || (st_after.phase == PH_TRAIL) ||
                  (st_after.phase == PH_DONE)) && !st_after.oor;
        sval   = st_after.is_neg ? -$signed(st_after.mag) : $signed(st_after.mag);
        res_value = res_ok ? OUT_BITS'(sval) : '0;

        st_next = last_byte ? STATE_RESET : st_after;
    end

endmodule

FILE: hdl/strict_decimal_int_parser.sv
`timescale 1ns / 1ps
// Strict decimal integer parser top level: input register, parser state, result register.
// Depends on sdip_pkg and sdip_step.
// Throughput: one byte beat per cycle unless a last beat waits for the result register;
// the running state is updated in a single step; the result of a last beat is registered.
// Backpressure: only a last beat waits for the result register to free up.
// Reset: aresetn synchronous, active low; clears beat valids and parser state.
module strict_decimal_int_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] char_byte
    input  logic                           s_tuser,   // [0] no_byte
    input  logic                           s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sdip_pkg::OUT_BITS-1:0]  m_tdata,   // [31:0] parsed_value
    output logic                           m_tuser    // [0] parse_ok
);
    import sdip_pkg::*;

    logic                  in_valid_reg;
    logic [BYTE_BITS-1:0]  in_byte_reg;
    logic                  in_none_reg;
    logic                  in_last_reg;
    parse_state_t          st_reg;
    parse_state_t          st_next;
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   out_value_reg;
    logic                  out_ok_reg;
    logic [OUT_BITS-1:0]   res_value;
    logic                  res_ok;
    logic                  out_free;
    logic                  advance;

    sdip_step u_step (
        .st        (st_reg),
        .char_byte (in_byte_reg),
        .no_byte   (in_none_reg),
        .last_byte (in_last_reg),
        .st_next   (st_next),
        .res_value (res_value),
        .res_ok    (res_ok)
    );

    assign out_free = !out_valid_reg || m_tready;
    // non-last beats never produce a result, so they never wait
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_none_reg <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= STATE_RESET;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_value_reg <= res_value;
            out_ok_reg    <= res_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_ok_reg;

endmodule

FILE: hdl/sdip_checker.sv
`timescale 1ns / 1ps
// Port-level checks for strict_decimal_int_parser, attached with bind.
// Depends on sdip_pkg.
module sdip_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sdip_pkg::OUT_BITS-1:0]  m_tdata,
    input  logic                           m_tuser
);
    import sdip_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // failed parse carries a zero value
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid result with nonzero value");

    // a fresh result follows an accepted last input beat
    a_rose_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result beat without preceding last beat");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind strict_decimal_int_parser sdip_checker u_sdip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
